>>> hw/rtl/nv12rgb_pkg.sv
// Shared types, constants and helpers for the NV12 pixel to RGB converter.
// No dependencies; imported by nv12_to_rgb_pixel_converter.
package nv12rgb_pkg;

	localparam int PIX_W   = 8;   // luma, chroma and color channel width
	localparam int DIM_W   = 13;  // frame_width / frame_height register width
	localparam int CFG_W   = 13;  // config write data, widest register
	localparam int CIDX_W  = 3;   // config register index width
	localparam int COEF_W  = 18;  // unsigned Q16 matrix coefficients
	localparam int PROD_W  = 28;  // signed Q16 products and scaled luma
	localparam int SUM_W   = 30;  // signed Q16 channel sums

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = DIM_W'(1920);
	localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = DIM_W'(1080);

	localparam logic [16:0]      LUMA_SCALE_Q16 = 17'd76309;
	localparam logic [PIX_W:0]   Y_BLACK        = 9'd16;
	localparam logic [PIX_W:0]   CHROMA_MID     = 9'd128;
	localparam logic [SUM_W-1:0] Q_HALF         = SUM_W'(32768);

	typedef enum logic [CIDX_W-1:0] {
		REG_USE_BT709     = 3'd0,
		REG_LIMITED_RANGE = 3'd1,
		REG_BGR_ORDER     = 3'd2,
		REG_FRAME_WIDTH   = 3'd3,
		REG_FRAME_HEIGHT  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [COEF_W-1:0] r_v;
		logic [COEF_W-1:0] g_u;
		logic [COEF_W-1:0] g_v;
		logic [COEF_W-1:0] b_u;
	} coef_t;

	// flags that ride along with each pixel word
	typedef struct packed {
		logic row_end;
		logic frame_end;
		logic status;
	} pix_flags_t;

	function automatic coef_t coef_lookup(input logic bt709, input logic limited);
		coef_t c;
		case ({bt709, limited})
			2'b00:   c = '{r_v: 18'd91881,  g_u: 18'd22553, g_v: 18'd46802, b_u: 18'd116130};
			2'b01:   c = '{r_v: 18'd104597, g_u: 18'd25675, g_v: 18'd53279, b_u: 18'd132201};
			2'b10:   c = '{r_v: 18'd103206, g_u: 18'd12276, g_v: 18'd30679, b_u: 18'd121609};
			default: c = '{r_v: 18'd117489, g_u: 18'd13975, g_v: 18'd34925, b_u: 18'd138438};
		endcase
		return c;
	endfunction

	// Negative sums round to zero or below and clamp to 0, so only the
	// positive branch of round-half-away-from-zero is needed.
	function automatic logic [PIX_W-1:0] round_clamp(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-1:0]  t;
		logic [SUM_W-17:0] q;
		logic [PIX_W-1:0]  r;
		t = $unsigned(v) + Q_HALF;
		q = t[SUM_W-1:16];
		if (v < 0)
			r = '0;
		else if (q > (SUM_W-16)'(255))
			r = '1;
		else
			r = q[PIX_W-1:0];
		return r;
	endfunction

endpackage

>>> hw/rtl/nv12_to_rgb_pixel_converter.sv
// NV12 pixel to RGB/BGR converter top level: three-stage pixel pipeline
// with row/frame position counters. Depends on nv12rgb_pkg.

// One pixel word per clock in, one per clock out while the output is not stalled:
// stage 1 registers the input and its row/frame flags, stage 2 registers the
// luma scale and the four chroma products, stage 3 registers the rounded and
// clamped channels. The whole pipeline advances whenever the output register
// is empty or being taken, so in_ready follows out_ready. Configuration is
// written through cfg_wr_en/cfg_index/cfg_data and must only change while the
// pipeline is empty. A zero, odd or oversized frame size sets status and
// holds the position counters at zero.
module nv12_to_rgb_pixel_converter
	import nv12rgb_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [PIX_W-1:0]  luma,
	input  logic [PIX_W-1:0]  cb_sample,
	input  logic [PIX_W-1:0]  cr_sample,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PIX_W-1:0]  first_channel,
	output logic [PIX_W-1:0]  green_channel,
	output logic [PIX_W-1:0]  third_channel,
	output logic              row_end,
	output logic              frame_end,
	output logic              status
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int CMPC_W = (COL_W + 1 > DIM_W + 1) ? COL_W + 1 : DIM_W + 1;
	localparam int CMPR_W = (ROW_W + 1 > DIM_W + 1) ? ROW_W + 1 : DIM_W + 1;

	// configuration
	logic             use_bt709_q, limited_range_q, bgr_order_q;
	logic [DIM_W-1:0] frame_width_q, frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_bt709_q     <= 1'b0;
			limited_range_q <= 1'b1;
			bgr_order_q     <= 1'b0;
			frame_width_q   <= RST_FRAME_WIDTH;
			frame_height_q  <= RST_FRAME_HEIGHT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_USE_BT709:     use_bt709_q     <= cfg_data[0];
				REG_LIMITED_RANGE: limited_range_q <= cfg_data[0];
				REG_BGR_ORDER:     bgr_order_q     <= cfg_data[0];
				REG_FRAME_WIDTH:   frame_width_q   <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT:  frame_height_q  <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic advance, accept;
	logic v_s1, v_s2;

	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;
	assign accept   = in_valid && in_ready;

	// position counters and frame size check
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [CMPC_W-1:0] col_next, width_x;
	logic [CMPR_W-1:0] row_next, height_x;
	logic              bad_size, row_last, frame_last;

	always_comb begin
		width_x    = CMPC_W'(frame_width_q);
		height_x   = CMPR_W'(frame_height_q);
		col_next   = CMPC_W'(col_q) + CMPC_W'(1);
		row_next   = CMPR_W'(row_q) + CMPR_W'(1);
		bad_size   = (frame_width_q == '0) || frame_width_q[0] ||
		             (width_x > CMPC_W'(MAX_WIDTH)) ||
		             (frame_height_q == '0) || frame_height_q[0] ||
		             (height_x > CMPR_W'(MAX_HEIGHT));
		row_last   = !bad_size && (col_next >= width_x);
		frame_last = row_last && (row_next >= height_x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (bad_size) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_last) begin
				col_q <= '0;
				row_q <= frame_last ? '0 : row_next[ROW_W-1:0];
			end else begin
				col_q <= col_next[COL_W-1:0];
			end
		end
	end

	// stage 1: input word and flags
	logic [PIX_W-1:0] luma_s1, cb_s1, cr_s1;
	pix_flags_t       flags_s1, flags_s2, flags_s3;

	always_ff @(posedge clk) begin
		if (accept) begin
			luma_s1  <= luma;
			cb_s1    <= cb_sample;
			cr_s1    <= cr_sample;
			flags_s1 <= '{row_end: row_last, frame_end: frame_last, status: bad_size};
		end
	end

	// stage 2: scaled luma and chroma products
	coef_t                    coef;
	logic signed [PIX_W:0]    y_off, cb_c, cr_c;
	logic signed [PROD_W-1:0] ys_s2, p_rv_s2, p_gu_s2, p_gv_s2, p_bu_s2;

	always_comb begin
		coef  = coef_lookup(use_bt709_q, limited_range_q);
		y_off = $signed({1'b0, luma_s1} - Y_BLACK);
		cb_c  = $signed({1'b0, cb_s1} - CHROMA_MID);
		cr_c  = $signed({1'b0, cr_s1} - CHROMA_MID);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (limited_range_q)
				ys_s2 <= PROD_W'($signed({1'b0, LUMA_SCALE_Q16}) * y_off);
			else
				ys_s2 <= $signed(PROD_W'({luma_s1, 16'b0}));
			p_rv_s2  <= PROD_W'($signed({1'b0, coef.r_v}) * cr_c);
			p_gu_s2  <= PROD_W'($signed({1'b0, coef.g_u}) * cb_c);
			p_gv_s2  <= PROD_W'($signed({1'b0, coef.g_v}) * cr_c);
			p_bu_s2  <= PROD_W'($signed({1'b0, coef.b_u}) * cb_c);
			flags_s2 <= flags_s1;
		end
	end

	// stage 3: sums, round, clamp, channel order
	logic signed [SUM_W-1:0] red_sum, green_sum, blue_sum;
	logic [PIX_W-1:0]        red, green, blue;
	logic [PIX_W-1:0]        first_s3, green_s3, third_s3;

	always_comb begin
		red_sum   = SUM_W'(ys_s2) + SUM_W'(p_rv_s2);
		green_sum = SUM_W'(ys_s2) - SUM_W'(p_gu_s2) - SUM_W'(p_gv_s2);
		blue_sum  = SUM_W'(ys_s2) + SUM_W'(p_bu_s2);
		red       = round_clamp(red_sum);
		green     = round_clamp(green_sum);
		blue      = round_clamp(blue_sum);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			first_s3 <= bgr_order_q ? blue : red;
			green_s3 <= green;
			third_s3 <= bgr_order_q ? red : blue;
			flags_s3 <= flags_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (advance) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	assign first_channel = first_s3;
	assign green_channel = green_s3;
	assign third_channel = third_s3;
	assign row_end       = flags_s3.row_end;
	assign frame_end     = flags_s3.frame_end;
	assign status        = flags_s3.status;

	// checks
	a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!frame_end || row_end))
		else $error("frame_end without row_end");

	a_bad_size_no_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (!row_end && !frame_end))
		else $error("row/frame mark on a bad frame size word");

	a_bad_size_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && bad_size) |=> (col_q == '0 && row_q == '0))
		else $error("counters not cleared on bad frame size");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(v_s1) && $stable(v_s2) && out_valid))
		else $error("pipeline moved while output stalled");

endmodule

>>> tb/tb_nv12_to_rgb_pixel_converter.sv
// Testbench for nv12_to_rgb_pixel_converter: drives pixel words through the
// valid/ready channels and checks every output word against a built-in predictor.
// Depends on nv12rgb_pkg and the converter RTL.
module tb_nv12_to_rgb_pixel_converter;
	timeunit 1ns;
	timeprecision 1ps;

	import nv12rgb_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_WORDS = 900;
	localparam logic [CIDX_W-1:0] CFG_IDX_SPARE = 3'd5;  // first index past the register list

	// Predicts the converted pixel and the row/frame flags for each accepted word.
	class pixel_scoreboard;
		typedef struct packed {
			logic [PIX_W-1:0] ch_first;
			logic [PIX_W-1:0] ch_green;
			logic [PIX_W-1:0] ch_third;
			logic             row_end;
			logic             frame_end;
			logic             status;
		} pixel_t;

		localparam longint LUMA_GAIN_Q16 = 76309;
		localparam longint LUMA_BLACK    = 16;
		localparam longint CHROMA_CENTER = 128;
		localparam longint Q16_HALF      = 32768;

		logic             use_709  = 1'b0;
		logic             limited  = 1'b1;
		logic             bgr      = 1'b0;
		logic [DIM_W-1:0] width    = 13'd1920;
		logic [DIM_W-1:0] height   = 13'd1080;
		int unsigned      col_pos  = 0;
		int unsigned      row_pos  = 0;
		pixel_t           pending[$];
		int               mismatches = 0;

		task report(string what, longint got, longint want);
			$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
			mismatches++;
		endtask

		function void set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_USE_BT709:     use_709 = data[0];
				REG_LIMITED_RANGE: limited = data[0];
				REG_BGR_ORDER:     bgr = data[0];
				REG_FRAME_WIDTH:   width = data;
				REG_FRAME_HEIGHT:  height = data;
				default: ;
			endcase
		endfunction

		function logic [PIX_W-1:0] to_channel(longint acc);
			longint r;
			if (acc >= 0)
				r = (acc + Q16_HALF) >>> 16;
			else
				r = -((-acc + Q16_HALF) >>> 16);
			if (r < 0)
				return '0;
			if (r > 255)
				return '1;
			return r[PIX_W-1:0];
		endfunction

		function void note_pixel(logic [PIX_W-1:0] y, logic [PIX_W-1:0] cb,
				logic [PIX_W-1:0] cr);
			pixel_t p;
			longint ys, u, v, kr, kgu, kgv, kb;
			logic [PIX_W-1:0] red, grn, blu;
			logic bad, last_col, last_row;
			u = longint'(cb) - CHROMA_CENTER;
			v = longint'(cr) - CHROMA_CENTER;
			case ({use_709, limited})
				2'b00: begin kr = 91881;  kgu = 22553; kgv = 46802; kb = 116130; end
				2'b01: begin kr = 104597; kgu = 25675; kgv = 53279; kb = 132201; end
				2'b10: begin kr = 103206; kgu = 12276; kgv = 30679; kb = 121609; end
				default: begin kr = 117489; kgu = 13975; kgv = 34925; kb = 138438; end
			endcase
			if (limited)
				ys = LUMA_GAIN_Q16 * (longint'(y) - LUMA_BLACK);
			else
				ys = longint'(y) * 65536;
			red = to_channel(ys + kr * v);
			grn = to_channel(ys - kgu * u - kgv * v);
			blu = to_channel(ys + kb * u);

			bad = width == 0 || width[0] || width > DEF_MAX_WIDTH ||
				height == 0 || height[0] || height > DEF_MAX_HEIGHT;
			last_col = 1'b0;
			last_row = 1'b0;
			if (bad) begin
				col_pos = 0;
				row_pos = 0;
			end else begin
				// a counter already past a shrunk size ends its row/frame at once
				last_col = col_pos + 1 >= width;
				last_row = last_col && (row_pos + 1 >= height);
				if (last_col) begin
					col_pos = 0;
					row_pos = last_row ? 0 : row_pos + 1;
				end else begin
					col_pos = col_pos + 1;
				end
			end
			p.ch_first  = bgr ? blu : red;
			p.ch_green  = grn;
			p.ch_third  = bgr ? red : blu;
			p.row_end   = last_col;
			p.frame_end = last_row;
			p.status    = bad;
			pending.push_back(p);
		endfunction

		task check_pixel(pixel_t got);
			pixel_t want;
			if (pending.size() == 0) begin
				report("unexpected word", 1, 0);
				return;
			end
			want = pending.pop_front();
			if (got.ch_first !== want.ch_first)
				report("first_channel", got.ch_first, want.ch_first);
			if (got.ch_green !== want.ch_green)
				report("green_channel", got.ch_green, want.ch_green);
			if (got.ch_third !== want.ch_third)
				report("third_channel", got.ch_third, want.ch_third);
			if (got.row_end !== want.row_end)
				report("row_end", got.row_end, want.row_end);
			if (got.frame_end !== want.frame_end)
				report("frame_end", got.frame_end, want.frame_end);
			if (got.status !== want.status)
				report("status", got.status, want.status);
		endtask

		function int outstanding();
			return pending.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [PIX_W-1:0]  luma = '0;
	logic [PIX_W-1:0]  cb_sample = '0;
	logic [PIX_W-1:0]  cr_sample = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [PIX_W-1:0]  first_channel;
	logic [PIX_W-1:0]  green_channel;
	logic [PIX_W-1:0]  third_channel;
	logic              row_end;
	logic              frame_end;
	logic              status;

	pixel_scoreboard sb;
	bit steady = 1'b0;  // no new gaps on either side while set
	int ready_left = 0;
	int quiet_cycles = 0;

	nv12_to_rgb_pixel_converter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.luma         (luma),
		.cb_sample    (cb_sample),
		.cr_sample    (cr_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.first_channel(first_channel),
		.green_channel(green_channel),
		.third_channel(third_channel),
		.row_end      (row_end),
		.frame_end    (frame_end),
		.status       (status)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (ready_left != 0) begin
			ready_left--;
		end else if (steady || $urandom_range(0, 3) != 0) begin
			out_ready <= 1'b1;
			ready_left = $urandom_range(0, 15);
		end else begin
			out_ready <= 1'b0;
			ready_left = idle_len();
		end
	end

	// accept monitor, config shadow and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				sb.set_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.note_pixel(luma, cb_sample, cr_sample);
			if (out_valid && out_ready)
				sb.check_pixel({first_channel, green_channel, third_channel,
					row_end, frame_end, status});
			if (cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Called right after the rising clock; returns once the word has been taken.
	task automatic send_pixel(logic [PIX_W-1:0] y, logic [PIX_W-1:0] cb, logic [PIX_W-1:0] cr);
		int gap;
		gap = steady ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		luma      <= y;
		cb_sample <= cb;
		cr_sample <= cr;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes all five registers; single-bit ones get junk in the upper bits.
	task automatic configure(logic bt709, logic lim, logic bgr, logic [DIM_W-1:0] w,
			logic [DIM_W-1:0] h, bit spare);
		cfg_reg_t idx;
		logic [CFG_W-1:0] data;
		for (int i = 0; i < 5; i++) begin
			idx = cfg_reg_t'(i);
			case (idx)
				REG_USE_BT709:     data = {(CFG_W-1)'($urandom_range(0, 4095)), bt709};
				REG_LIMITED_RANGE: data = {(CFG_W-1)'($urandom_range(0, 4095)), lim};
				REG_BGR_ORDER:     data = {(CFG_W-1)'($urandom_range(0, 4095)), bgr};
				REG_FRAME_WIDTH:   data = w;
				default:           data = h;
			endcase
			cfg_wr_en <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= data;
			@(posedge clk);
		end
		if (spare) begin
			cfg_index <= CFG_IDX_SPARE + CIDX_W'($urandom_range(0, 2));
			cfg_data  <= CFG_W'($urandom);
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [DIM_W-1:0] pick_dim();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return DIM_W'(2 * $urandom_range(1, 8));
		if (r < 80)
			return DIM_W'(2 * $urandom_range(9, 2048));
		if (r < 85)
			return DIM_W'(DEF_MAX_WIDTH);
		if (r < 90)
			return '0;
		if (r < 95)
			return DIM_W'(2 * $urandom_range(0, 4095) + 1);
		return DIM_W'($urandom_range(4097, 8191));
	endfunction

	function automatic logic [PIX_W-1:0] pick_sample();
		logic [PIX_W-1:0] corner [5] = '{8'd0, 8'd255, 8'd16, 8'd235, 8'd128};
		if ($urandom_range(0, 9) == 0)
			return corner[3'($urandom_range(0, 4))];
		return PIX_W'($urandom);
	endfunction

	initial begin
		logic [23:0] corner_px [8];
		int sent;
		int n;
		corner_px = '{24'h000000, 24'hFFFFFF, 24'h00FF00, 24'hFF00FF,
			24'h108080, 24'hEB8080, 24'hFF0000, 24'h00FFFF};
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// color extremes with the reset settings
		foreach (corner_px[i])
			send_pixel(corner_px[i][23:16], corner_px[i][15:8], corner_px[i][7:0]);
		settle();
		// shrink to 2x2 mid-row: the first word ends its row at once
		configure(1'b1, 1'b0, 1'b1, 13'd2, 13'd2, 1'b1);
		for (int i = 0; i < 4; i++)
			send_pixel(corner_px[i][23:16], corner_px[i][15:8], corner_px[i][7:0]);
		settle();
		configure(1'b0, 1'b0, 1'b0, 13'd8, 13'd4, 1'b0);
		for (int i = 4; i < 7; i++)
			send_pixel(corner_px[i][23:16], corner_px[i][15:8], corner_px[i][7:0]);
		settle();
		// bad frame sizes: zero, odd, oversized; then the largest valid size
		configure(1'b1, 1'b1, 1'b0, 13'd0, 13'd4, 1'b0);
		send_pixel(8'd255, 8'd0, 8'd255);
		settle();
		configure(1'b1, 1'b1, 1'b1, 13'd3, 13'd4, 1'b0);
		send_pixel(8'd0, 8'd255, 8'd0);
		settle();
		configure(1'b0, 1'b1, 1'b0, 13'd4098, 13'd4, 1'b0);
		send_pixel(8'd128, 8'd128, 8'd128);
		settle();
		configure(1'b0, 1'b0, 1'b1, 13'd4, 13'd7, 1'b0);
		send_pixel(8'd235, 8'd16, 8'd240);
		settle();
		configure(1'b1, 1'b0, 1'b0, 13'd4, 13'd8191, 1'b0);
		send_pixel(8'd16, 8'd240, 8'd16);
		settle();
		configure(1'b0, 1'b1, 1'b1, 13'd4096, 13'd4096, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		settle();

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			configure($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
				pick_dim(), pick_dim(), $urandom_range(0, 9) == 0);
			steady = $urandom_range(0, 5) == 0;
			n = $urandom_range(8, 60);
			repeat (n)
				send_pixel(pick_sample(), pick_sample(), pick_sample());
			sent += n;
			settle();
			steady = 1'b0;
		end

		if (sb.outstanding() != 0)
			sb.report("words never seen", 0, sb.outstanding());
		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/nv12rgb_pkg.sv
hw/rtl/nv12_to_rgb_pixel_converter.sv
tb/tb_nv12_to_rgb_pixel_converter.sv
